### rtl/life_automaton_grid_top_defines.svh
// ----------------------------------------------------------------------------
// life_automaton_grid_top_defines.svh
// Assertion macros shared by the life grid modules
// ----------------------------------------------------------------------------
`ifndef LIFE_AUTOMATON_GRID_TOP_DEFINES_SVH
`define LIFE_AUTOMATON_GRID_TOP_DEFINES_SVH

// same-cycle implication, sampled on aclk, off during reset
`define LAG_ASSERT_SAME(label, pre, post, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication, sampled on aclk, off during reset
`define LAG_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error(msg);

`endif

### rtl/lag_pkg.sv
// ----------------------------------------------------------------------------
// lag_pkg
// Types, codes and constants of the life automaton grid
// ----------------------------------------------------------------------------
package lag_pkg;

    // field widths
    localparam int ROW_W  = 6;
    localparam int COL_W  = 6;
    localparam int LIVE_W = 13;

    // default grid size
    localparam int ROWS_DEFAULT = 64;
    localparam int COLS_DEFAULT = 64;

    // rule B3/S23 and output saturation
    localparam int BORN_COUNT = 3;
    localparam int STAY_LOW   = 2;
    localparam int STAY_HIGH  = 3;
    localparam int LIVE_MAX   = 8191;

    // command codes
    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_READ  = 2'd1,
        CMD_STEP  = 2'd2,
        CMD_NONE  = 2'd3
    } lag_cmd_t;

    // input item
    typedef struct packed {
        lag_cmd_t           command;
        logic [ROW_W-1:0]   row;
        logic [COL_W-1:0]   column;
        logic               cell_in;
    } lag_in_t;

    // result item
    typedef struct packed {
        logic               cell_out;
        logic [LIVE_W-1:0]  live_total;
    } lag_out_t;

    // controller states
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FETCH,
        ST_APPLY,
        ST_START,
        ST_LOAD_B,
        ST_LOAD_C,
        ST_SCAN,
        ST_WB,
        ST_FILL,
        ST_RESULT
    } lag_state_t;

    // controller to datapath commands
    typedef struct packed {
        logic clr_row;
        logic load_in;
        logic acc_read;
        logic acc_apply;
        logic step_start;
        logic step_load_b;
        logic step_load_c;
        logic scan;
        logic wb;
        logic fill;
        logic out_load;
    } lag_ctrl_t;

    // datapath to controller status
    typedef struct packed {
        logic row_last;
        logic col_last;
        logic out_free;
    } lag_stat_t;

endpackage

### rtl/life_automaton_grid_top.sv
// Write and read: states FETCH, APPLY, RESULT; an unused code goes straight to RESULT.
// Step: a one-cell-per-cycle row scan over a row-wide memory with one read,
//   one write port.
// One item at a time; the next item can be taken once a result is registered.
// Reset (aresetn low, synchronous) starts a clearing pass over all GRID_ROWS rows,
//   one row per cycle, during which no item is accepted.
// ----------------------------------------------------------------------------
// life_automaton_grid_top
// Conway B3/S23 grid with single-cell write and read and whole-grid step
// ----------------------------------------------------------------------------
module life_automaton_grid_top #(
    parameter int GRID_ROWS = lag_pkg::ROWS_DEFAULT,
    parameter int GRID_COLS = lag_pkg::COLS_DEFAULT
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  lag_pkg::lag_in_t   s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output lag_pkg::lag_out_t  m_data
);
    import lag_pkg::*;

    lag_ctrl_t ctrl;
    lag_stat_t stat;

    // sequencer
    lag_controller u_controller (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_command (s_data.command),
        .stat      (stat),
        .ctrl      (ctrl)
    );

    // grid storage and cell rule
    lag_datapath #(
        .GRID_ROWS (GRID_ROWS),
        .GRID_COLS (GRID_COLS)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .ctrl    (ctrl),
        .stat    (stat),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .m_data  (m_data)
    );

endmodule

### rtl/lag_datapath.sv
// ----------------------------------------------------------------------------
// lag_datapath
// Row-wide grid memory, three-row window, cell rule, live count, result register
// ----------------------------------------------------------------------------
`include "life_automaton_grid_top_defines.svh"

module lag_datapath #(
    parameter int GRID_ROWS = lag_pkg::ROWS_DEFAULT,
    parameter int GRID_COLS = lag_pkg::COLS_DEFAULT
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  lag_pkg::lag_in_t    s_data,
    input  lag_pkg::lag_ctrl_t  ctrl,
    output lag_pkg::lag_stat_t  stat,
    input  logic                m_ready,
    output logic                m_valid,
    output lag_pkg::lag_out_t   m_data
);
    import lag_pkg::*;

    localparam int RW  = $clog2(GRID_ROWS);
    localparam int CLW = $clog2(GRID_COLS);
    localparam int RXW = ($clog2(GRID_ROWS + 1) > ROW_W) ? $clog2(GRID_ROWS + 1) : ROW_W;
    localparam int CXW = ($clog2(GRID_COLS + 1) > COL_W) ? $clog2(GRID_COLS + 1) : COL_W;
    localparam int LW  = $clog2(GRID_ROWS * GRID_COLS + 1);
    localparam int OW  = (LW > LIVE_W) ? LW : LIVE_W;

    // grid memory, one row per entry
    logic [GRID_COLS-1:0] grid_mem [GRID_ROWS];

    // registers
    lag_in_t              item_reg;
    logic [GRID_COLS-1:0] rd_data_reg;
    logic [GRID_COLS-1:0] up_reg;
    logic [GRID_COLS-1:0] mid_reg;
    logic [GRID_COLS-1:0] dn_reg;
    logic [GRID_COLS-1:0] new_row_reg;
    logic [RW-1:0]        row_cnt_reg;
    logic [CLW-1:0]       col_cnt_reg;
    logic [LW-1:0]        live_reg;
    logic                 fill_zero_reg;
    logic                 read_bit_reg;
    logic                 m_valid_reg;
    lag_out_t             m_data_reg;

    // combinational signals
    logic [RXW-1:0]       row_ext;
    logic [CXW-1:0]       col_ext;
    logic [RW-1:0]        row_idx;
    logic [CLW-1:0]       col_idx;
    logic                 in_grid;
    logic                 old_bit;
    logic [GRID_COLS-1:0] wr_row;
    logic                 rd_en;
    logic [RW-1:0]        rd_addr;
    logic                 wr_en;
    logic [RW-1:0]        wr_addr;
    logic [GRID_COLS-1:0] wr_data;
    logic [RW:0]          row_plus2;
    logic                 row_plus2_ok;
    logic                 row_last;
    logic                 col_last;
    logic [2:0]           left_bits;
    logic [2:0]           right_bits;
    logic [3:0]           nbr_cnt;
    logic                 new_bit;
    logic                 out_free;
    logic [OW-1:0]        live_ext;
    logic [LIVE_W-1:0]    live_sat;
    logic                 live_up;
    logic                 live_down;

    // addressing of the held item
    assign row_ext = RXW'(item_reg.row);
    assign col_ext = CXW'(item_reg.column);
    assign row_idx = row_ext[RW-1:0];
    assign col_idx = col_ext[CLW-1:0];
    assign in_grid = (row_ext < RXW'(GRID_ROWS)) && (col_ext < CXW'(GRID_COLS));
    assign old_bit = rd_data_reg[col_idx];

    // row with the addressed cell replaced
    always_comb begin
        wr_row          = rd_data_reg;
        wr_row[col_idx] = item_reg.cell_in;
    end

    // scan position flags
    assign row_last     = (row_cnt_reg == RW'(GRID_ROWS - 1));
    assign col_last     = (col_cnt_reg == CLW'(GRID_COLS - 1));
    assign row_plus2    = {1'b0, row_cnt_reg} + (RW + 1)'(2);
    assign row_plus2_ok = (row_plus2 < (RW + 1)'(GRID_ROWS));

    // 3x3 window at the current column, edges dead
    assign left_bits  = {up_reg[GRID_COLS-1], mid_reg[GRID_COLS-1], dn_reg[GRID_COLS-1]}
                        & {3{col_cnt_reg != '0}};
    assign right_bits = {up_reg[1], mid_reg[1], dn_reg[1]} & {3{!col_last}};
    assign nbr_cnt    = 4'(left_bits[0]) + 4'(left_bits[1]) + 4'(left_bits[2])
                        + 4'(right_bits[0]) + 4'(right_bits[1]) + 4'(right_bits[2])
                        + 4'(up_reg[0]) + 4'(dn_reg[0]);

    // B3/S23
    assign new_bit = mid_reg[0] ? ((nbr_cnt == 4'(STAY_LOW)) || (nbr_cnt == 4'(STAY_HIGH)))
                                : (nbr_cnt == 4'(BORN_COUNT));

    // live count changes on a single-cell write
    assign live_up   = ctrl.acc_apply && (item_reg.command == CMD_WRITE) && in_grid
                       && (old_bit != item_reg.cell_in) && item_reg.cell_in;
    assign live_down = ctrl.acc_apply && (item_reg.command == CMD_WRITE) && in_grid
                       && (old_bit != item_reg.cell_in) && !item_reg.cell_in;

    // saturated live total
    assign live_ext = OW'(live_reg);
    assign live_sat = (live_ext > OW'(LIVE_MAX)) ? LIVE_W'(LIVE_MAX) : live_ext[LIVE_W-1:0];

    // memory port selection
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = row_idx;
        wr_en   = 1'b0;
        wr_addr = row_cnt_reg;
        wr_data = new_row_reg;
        if (ctrl.clr_row) begin
            wr_en   = 1'b1;
            wr_data = '0;
        end
        if (ctrl.acc_read) begin
            rd_en = 1'b1;
        end
        if (ctrl.acc_apply && (item_reg.command == CMD_WRITE) && in_grid) begin
            wr_en   = 1'b1;
            wr_addr = row_idx;
            wr_data = wr_row;
        end
        if (ctrl.step_start) begin
            rd_en   = 1'b1;
            rd_addr = '0;
        end
        if (ctrl.step_load_b) begin
            rd_en   = 1'b1;
            rd_addr = RW'(1);
        end
        if (ctrl.wb) begin
            wr_en   = 1'b1;
            rd_en   = row_plus2_ok;
            rd_addr = row_plus2[RW-1:0];
        end
    end

    // grid memory write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            grid_mem[wr_addr] <= wr_data;
        end
    end

    // grid memory read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= grid_mem[rd_addr];
        end
    end

    // counters, live count and result valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_cnt_reg <= '0;
            col_cnt_reg <= '0;
            live_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (ctrl.clr_row || ctrl.wb) begin
                row_cnt_reg <= row_last ? '0 : row_cnt_reg + RW'(1);
            end else if (ctrl.step_start) begin
                row_cnt_reg <= '0;
            end
            if (ctrl.scan) begin
                col_cnt_reg <= col_last ? '0 : col_cnt_reg + CLW'(1);
            end else if (ctrl.step_start) begin
                col_cnt_reg <= '0;
            end
            if (ctrl.step_start) begin
                live_reg <= '0;
            end else if (ctrl.scan) begin
                live_reg <= live_reg + LW'(new_bit);
            end else if (live_up) begin
                live_reg <= live_reg + LW'(1);
            end else if (live_down) begin
                live_reg <= live_reg - LW'(1);
            end
            if (ctrl.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // row window, new row and result payload
    always_ff @(posedge aclk) begin
        if (ctrl.load_in) begin
            item_reg     <= s_data;
            read_bit_reg <= 1'b0;
        end
        if (ctrl.acc_apply) begin
            read_bit_reg <= (item_reg.command == CMD_READ) && in_grid && old_bit;
        end
        if (ctrl.step_start) begin
            up_reg <= '0;
        end
        if (ctrl.step_load_b) begin
            mid_reg <= rd_data_reg;
        end
        if (ctrl.step_load_c) begin
            dn_reg <= rd_data_reg;
        end
        if (ctrl.scan) begin
            up_reg      <= {up_reg[0], up_reg[GRID_COLS-1:1]};
            mid_reg     <= {mid_reg[0], mid_reg[GRID_COLS-1:1]};
            dn_reg      <= {dn_reg[0], dn_reg[GRID_COLS-1:1]};
            new_row_reg <= {new_bit, new_row_reg[GRID_COLS-1:1]};
        end
        if (ctrl.wb) begin
            up_reg        <= mid_reg;
            mid_reg       <= dn_reg;
            fill_zero_reg <= !row_plus2_ok;
        end
        if (ctrl.fill) begin
            dn_reg <= fill_zero_reg ? '0 : rd_data_reg;
        end
        if (ctrl.out_load) begin
            m_data_reg.cell_out   <= read_bit_reg;
            m_data_reg.live_total <= live_sat;
        end
    end

    // status and outputs
    assign out_free      = !m_valid_reg || m_ready;
    assign stat.row_last = row_last;
    assign stat.col_last = col_last;
    assign stat.out_free = out_free;
    assign m_valid       = m_valid_reg;
    assign m_data        = m_data_reg;

    // checks
    `LAG_ASSERT_SAME(a_live_bound, 1'b1, live_reg <= LW'(GRID_ROWS * GRID_COLS),
        "live count above cell count")
    `LAG_ASSERT_SAME(a_wb_full_row, ctrl.wb, col_cnt_reg == '0,
        "row written back before a full scan")
    `LAG_ASSERT_SAME(a_load_free, ctrl.out_load, out_free,
        "result loaded over an untaken item")

endmodule

### rtl/lag_controller.sv
// ----------------------------------------------------------------------------
// lag_controller
// Sequencer for clearing, cell access and generation steps
// ----------------------------------------------------------------------------
`include "life_automaton_grid_top_defines.svh"

module lag_controller (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  lag_pkg::lag_cmd_t   s_command,
    input  lag_pkg::lag_stat_t  stat,
    output lag_pkg::lag_ctrl_t  ctrl
);
    import lag_pkg::*;

    lag_state_t state_reg;
    lag_state_t state_next;
    logic       accept;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next = state_reg;
        ctrl       = '0;
        unique case (state_reg)
            ST_CLEAR: begin
                ctrl.clr_row = 1'b1;
                if (stat.row_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    ctrl.load_in = 1'b1;
                    unique case (s_command) inside
                        CMD_WRITE, CMD_READ: state_next = ST_FETCH;
                        CMD_STEP:            state_next = ST_START;
                        default:             state_next = ST_RESULT;
                    endcase
                end
            end
            ST_FETCH: begin
                ctrl.acc_read = 1'b1;
                state_next    = ST_APPLY;
            end
            ST_APPLY: begin
                ctrl.acc_apply = 1'b1;
                state_next     = ST_RESULT;
            end
            ST_START: begin
                ctrl.step_start = 1'b1;
                state_next      = ST_LOAD_B;
            end
            ST_LOAD_B: begin
                ctrl.step_load_b = 1'b1;
                state_next       = ST_LOAD_C;
            end
            ST_LOAD_C: begin
                ctrl.step_load_c = 1'b1;
                state_next       = ST_SCAN;
            end
            ST_SCAN: begin
                ctrl.scan = 1'b1;
                if (stat.col_last) begin
                    state_next = ST_WB;
                end
            end
            ST_WB: begin
                ctrl.wb    = 1'b1;
                state_next = stat.row_last ? ST_RESULT : ST_FILL;
            end
            ST_FILL: begin
                ctrl.fill  = 1'b1;
                state_next = ST_SCAN;
            end
            ST_RESULT: begin
                if (stat.out_free) begin
                    ctrl.out_load = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // checks
    `LAG_ASSERT_NEXT(a_last_row_done, (state_reg == ST_WB) && stat.row_last,
        state_reg == ST_RESULT, "step did not finish after the last row")
    `LAG_ASSERT_NEXT(a_scan_stays, (state_reg == ST_SCAN) && !stat.col_last,
        state_reg == ST_SCAN, "row scan left early")
    `LAG_ASSERT_SAME(a_one_mem_op, 1'b1,
        $onehot0({ctrl.clr_row, ctrl.acc_read, ctrl.acc_apply, ctrl.step_start,
                  ctrl.step_load_b, ctrl.wb}),
        "more than one memory operation at once")

endmodule

### test/life_automaton_grid_top_tb.sv
// ----------------------------------------------------------------------------
// life_automaton_grid_top_tb
// Checks the life grid against a cell-level model of rule B3/S23 kept in the
// bench: a table of directed commands, then random noise items and write
// bursts into small windows followed by generation steps and nearby reads.
// ----------------------------------------------------------------------------
module life_automaton_grid_top_tb;
    import lag_pkg::*;

    localparam int ROWS         = ROWS_DEFAULT;
    localparam int COLS         = COLS_DEFAULT;
    localparam int RANDOM_ITEMS = 110;
    localparam int PHASE_A_END  = 60;
    localparam int PHASE_B_END  = 115;
    localparam int QUIET_LIMIT  = 20000;
    localparam int HOLD_AFTER   = 40;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 16;

    // one directed command, with its result where it is obvious
    typedef struct packed {
        lag_in_t  stim;
        logic     known;
        lag_out_t want;
    } probe_t;

    localparam int N_PROBES = 25;
    localparam probe_t PROBES [N_PROBES] = '{
        // empty grid straight after reset
        '{'{CMD_READ,  6'd0,  6'd0,  1'b0}, 1'b1, '{1'b0, 13'd0}},
        '{'{CMD_READ,  6'd63, 6'd63, 1'b0}, 1'b1, '{1'b0, 13'd0}},
        '{'{CMD_NONE,  6'd0,  6'd0,  1'b0}, 1'b1, '{1'b0, 13'd0}},
        '{'{CMD_STEP,  6'd0,  6'd0,  1'b0}, 1'b1, '{1'b0, 13'd0}},
        // corner cells, rewrite of the same value
        '{'{CMD_WRITE, 6'd0,  6'd0,  1'b1}, 1'b1, '{1'b0, 13'd1}},
        '{'{CMD_WRITE, 6'd0,  6'd0,  1'b1}, 1'b1, '{1'b0, 13'd1}},
        '{'{CMD_READ,  6'd0,  6'd0,  1'b0}, 1'b1, '{1'b1, 13'd1}},
        '{'{CMD_WRITE, 6'd63, 6'd63, 1'b1}, 1'b1, '{1'b0, 13'd2}},
        '{'{CMD_WRITE, 6'd0,  6'd63, 1'b1}, 1'b1, '{1'b0, 13'd3}},
        '{'{CMD_WRITE, 6'd63, 6'd0,  1'b1}, 1'b1, '{1'b0, 13'd4}},
        '{'{CMD_NONE,  6'd63, 6'd63, 1'b1}, 1'b1, '{1'b0, 13'd4}},
        // lone corner cells all die, no wraparound
        '{'{CMD_STEP,  6'd63, 6'd63, 1'b1}, 1'b1, '{1'b0, 13'd0}},
        '{'{CMD_WRITE, 6'd63, 6'd63, 1'b0}, 1'b1, '{1'b0, 13'd0}},
        // corner L shape grows into a block
        '{'{CMD_WRITE, 6'd0,  6'd0,  1'b1}, 1'b1, '{1'b0, 13'd1}},
        '{'{CMD_WRITE, 6'd0,  6'd1,  1'b1}, 1'b1, '{1'b0, 13'd2}},
        '{'{CMD_WRITE, 6'd1,  6'd0,  1'b1}, 1'b1, '{1'b0, 13'd3}},
        '{'{CMD_STEP,  6'd0,  6'd0,  1'b0}, 1'b0, '0},
        '{'{CMD_READ,  6'd1,  6'd1,  1'b0}, 1'b0, '0},
        // blinker on the bottom edge, clipped by the border
        '{'{CMD_WRITE, 6'd63, 6'd30, 1'b1}, 1'b0, '0},
        '{'{CMD_WRITE, 6'd63, 6'd31, 1'b1}, 1'b0, '0},
        '{'{CMD_WRITE, 6'd63, 6'd32, 1'b1}, 1'b0, '0},
        '{'{CMD_STEP,  6'd42, 6'd21, 1'b1}, 1'b0, '0},
        '{'{CMD_READ,  6'd62, 6'd31, 1'b0}, 1'b0, '0},
        '{'{CMD_WRITE, 6'd1,  6'd1,  1'b0}, 1'b0, '0},
        '{'{CMD_STEP,  6'd21, 6'd42, 1'b0}, 1'b0, '0}
    };

    logic     aclk;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    lag_in_t  s_data;
    logic     m_valid;
    logic     m_ready;
    lag_out_t m_data;

    // model of the grid and the results still owed by the block
    bit       life_grid [ROWS][COLS];
    int       live_count;
    lag_out_t grid_answers [$];

    int fail_count    = 0;
    int items_taken   = 0;
    int results_taken = 0;
    int quiet_cycles  = 0;
    bit hold_done     = 1'b0;

    life_automaton_grid_top dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // apply one command to the model grid and return its result
    function automatic lag_out_t grid_apply(input lag_in_t item);
        lag_out_t res;
        bit       next_gen [ROWS][COLS];
        int       nb;
        int       total;
        int       r;
        int       c;
        int       dr;
        int       dc;
        bit       in_grid;
        res     = '0;
        in_grid = (item.row < ROWS) && (item.column < COLS);
        case (item.command)
            CMD_WRITE: begin
                if (in_grid && life_grid[item.row][item.column] != item.cell_in) begin
                    life_grid[item.row][item.column] = item.cell_in;
                    live_count += item.cell_in ? 1 : -1;
                end
            end
            CMD_READ: begin
                if (in_grid)
                    res.cell_out = life_grid[item.row][item.column];
            end
            CMD_STEP: begin
                total = 0;
                for (r = 0; r < ROWS; r++) begin
                    for (c = 0; c < COLS; c++) begin
                        nb = 0;
                        for (dr = -1; dr <= 1; dr++) begin
                            for (dc = -1; dc <= 1; dc++) begin
                                if ((dr != 0 || dc != 0) && r + dr >= 0 && r + dr < ROWS &&
                                    c + dc >= 0 && c + dc < COLS)
                                    nb += life_grid[r + dr][c + dc];
                            end
                        end
                        if (life_grid[r][c])
                            next_gen[r][c] = (nb >= STAY_LOW) && (nb <= STAY_HIGH);
                        else
                            next_gen[r][c] = (nb == BORN_COUNT);
                        total += next_gen[r][c];
                    end
                end
                life_grid  = next_gen;
                live_count = total;
            end
            default: ;
        endcase
        res.live_total = (live_count > LIVE_MAX) ? LIVE_W'(LIVE_MAX) : LIVE_W'(live_count);
        return res;
    endfunction

    // offer one item, wait for it to be taken, then log what it should give
    task automatic issue(input lag_in_t item, input logic known, input lag_out_t want);
        lag_out_t predicted;
        int       gap_pct;
        gap_pct = (items_taken < PHASE_A_END) ? 38 : (items_taken < PHASE_B_END) ? 79 : 0;
        while ($urandom_range(0, 99) < gap_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        items_taken++;
        predicted = grid_apply(item);
        grid_answers.push_back(known ? want : predicted);
    endtask

    // window corner: often on the border, else anywhere
    function automatic logic [5:0] window_origin();
        case ($urandom_range(0, 3))
            0:       return 6'd0;
            1:       return 6'd60;
            default: return 6'($urandom_range(0, 60));
        endcase
    endfunction

    // stimulus
    initial begin
        lag_in_t    item;
        logic [5:0] r0;
        logic [5:0] c0;
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_data  <= '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < N_PROBES; i++)
            issue(PROBES[i].stim, PROBES[i].known, PROBES[i].want);

        while (items_taken < N_PROBES + RANDOM_ITEMS) begin
            if ($urandom_range(0, 9) < 8) begin
                // burst of writes into a 4x4 window, then steps, then nearby reads
                r0 = window_origin();
                c0 = window_origin();
                repeat ($urandom_range(4, 9)) begin
                    item.command = CMD_WRITE;
                    item.row     = r0 + 6'($urandom_range(0, 3));
                    item.column  = c0 + 6'($urandom_range(0, 3));
                    item.cell_in = ($urandom_range(0, 3) != 0);
                    issue(item, 1'b0, '0);
                end
                repeat ($urandom_range(1, 2)) begin
                    item.command = CMD_STEP;
                    item.row     = 6'($urandom);
                    item.column  = 6'($urandom);
                    item.cell_in = 1'($urandom);
                    issue(item, 1'b0, '0);
                end
                repeat ($urandom_range(2, 5)) begin
                    item.command = CMD_READ;
                    item.row     = r0 - 6'd1 + 6'($urandom_range(0, 5));
                    item.column  = c0 - 6'd1 + 6'($urandom_range(0, 5));
                    item.cell_in = 1'($urandom);
                    issue(item, 1'b0, '0);
                end
            end else begin
                // noise: any code, anywhere, but no steps
                item.command = lag_cmd_t'($urandom_range(0, 3));
                if (item.command == CMD_STEP)
                    item.command = CMD_NONE;
                item.row     = 6'($urandom);
                item.column  = 6'($urandom);
                item.cell_in = 1'($urandom);
                issue(item, 1'b0, '0);
            end
        end
        s_valid <= 1'b0;

        while (grid_answers.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0 && grid_answers.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // result side: random back-pressure, one long hold, field checks
    initial begin
        lag_out_t want;
        int       idle_pct;
        forever begin
            if (results_taken == HOLD_AFTER && !hold_done) begin
                hold_done = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                idle_pct = (items_taken < PHASE_A_END) ? 79 :
                           (items_taken < PHASE_B_END) ? 38 : 0;
                m_ready <= ($urandom_range(0, 99) >= idle_pct);
                @(posedge aclk);
                if (aresetn && m_valid && m_ready) begin
                    if (grid_answers.size() == 0) begin
                        $error("stray result: cell_out %0d live_total %0d",
                               m_data.cell_out, m_data.live_total);
                        fail_count++;
                    end else begin
                        want = grid_answers.pop_front();
                        if (m_data.cell_out !== want.cell_out) begin
                            $error("cell_out: expected %0d, got %0d",
                                   want.cell_out, m_data.cell_out);
                            fail_count++;
                        end
                        if (m_data.live_total !== want.live_total) begin
                            $error("live_total: expected %0d, got %0d",
                                   want.live_total, m_data.live_total);
                            fail_count++;
                        end
                    end
                    results_taken++;
                end
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule
